FILE: hw/rtl/heightmap_normal_stencil_macros.svh
// Assertion macros shared by the height map normal stencil RTL.
`ifndef HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH
`define HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH
`ifndef SYNTHESIS
`define HNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HNS_ASSERT(lbl, ante |=> cons, msg)
`else
`define HNS_ASSERT(lbl, prop, msg)
`define HNS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/hns_pkg.sv
// Types and constants of the height map normal stencil.
package hns_pkg;

  localparam logic [1:0] CFG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [1:0] CFG_GRID_STEP = 2'd2;

  localparam int unsigned NORM_ONE = 16384;
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned MIN_DIM  = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIVLOAD,
    N_DIVIDE,
    N_DONE
  } norm_state_e;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic        [14:0] nz;
  } norm_res_t;

endpackage

FILE: hw/rtl/hns_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/hns_norm.sv
// Iterative vector normalizer: scale, sum of squares, square root, three divides.
module hns_norm
  import hns_pkg::*;
#(
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [HEIGHT_BITS:0] dx_i,
  input  logic signed [HEIGHT_BITS:0] dy_i,
  input  logic [16:0]            dz_i,
  output norm_res_t              res_o
);
  localparam int unsigned MW = HEIGHT_BITS + 1;
  localparam int unsigned XW = (MW > 21) ? MW : 21;

  norm_state_e state_q, state_d;
  logic [XW-1:0] mag_q [3];
  logic [XW-1:0] mag_d [3];
  logic [1:0]  neg_q, neg_d;
  logic [1:0]  sel_q, sel_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [43:0] acc_q, acc_d;
  logic [43:0] root_q, root_d;
  logic [43:0] bit_q, bit_d;
  logic [21:0] len_q, len_d;
  logic [35:0] rem_q, rem_d;
  logic [36:0] dvs_q, dvs_d;
  logic [15:0] quo_q, quo_d;
  logic signed [15:0] nx_q, nx_d, ny_q, ny_d;
  logic [14:0] nz_q, nz_d;

  logic [XW-1:0] mmax, hi;
  logic [20:0]   msel;
  logic [41:0]   prod;
  logic [43:0]   trial;
  logic          ge;
  logic [15:0]   qfin, qclip;

  always_comb begin
    mmax = mag_q[0];
    if (mag_q[1] > mmax) mmax = mag_q[1];
    if (mag_q[2] > mmax) mmax = mag_q[2];
    hi    = mmax >> 20;
    msel  = mag_q[sel_q][20:0];
    prod  = 42'(msel) * 42'(msel);
    trial = root_q + bit_q;
    ge    = {1'b0, rem_q} >= dvs_q;
    qfin  = {quo_q[14:0], ge};
    qclip = (32'(qfin) > NORM_ONE) ? 16'(NORM_ONE) : qfin;
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    root_d  = root_q;
    bit_d   = bit_q;
    len_d   = len_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    nz_d    = nz_q;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          neg_d[0] = dx_i[HEIGHT_BITS];
          neg_d[1] = dy_i[HEIGHT_BITS];
          mag_d[0] = XW'(dx_i[HEIGHT_BITS] ? MW'(-dx_i) : MW'(dx_i));
          mag_d[1] = XW'(dy_i[HEIGHT_BITS] ? MW'(-dy_i) : MW'(dy_i));
          mag_d[2] = XW'(dz_i);
          state_d  = N_SHIFT;
        end
      end
      N_SHIFT: begin
        // One bit per cycle until the largest magnitude lies in [2^20, 2^21).
        if (hi == '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else if (hi != XW'(1)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else begin
          sel_d   = 2'd0;
          acc_d   = '0;
          state_d = N_SQUARE;
        end
      end
      N_SQUARE: begin
        acc_d = acc_q + 44'(prod);
        sel_d = sel_q + 2'd1;
        if (sel_q == 2'd2) begin
          root_d  = '0;
          bit_d   = 44'(1) << 42;
          cnt_d   = '0;
          state_d = N_ROOT;
        end
      end
      N_ROOT: begin
        if (acc_q >= trial) begin
          acc_d  = acc_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd21) begin
          sel_d   = 2'd0;
          state_d = N_DIVLOAD;
        end
      end
      N_DIVLOAD: begin
        if (cnt_q == 5'd22) begin
          len_d = root_q[21:0];
          rem_d = {1'b0, msel, 14'd0} + 36'(root_q[21:1]);
          dvs_d = {root_q[21:0], 15'd0};
        end else begin
          rem_d = {1'b0, msel, 14'd0} + 36'(len_q[21:1]);
          dvs_d = {len_q, 15'd0};
        end
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DIVIDE;
      end
      N_DIVIDE: begin
        if (ge) rem_d = rem_q - dvs_q[35:0];
        dvs_d = dvs_q >> 1;
        quo_d = qfin;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          case (sel_q)
            2'd0:    nx_d = neg_q[0] ? -$signed(qclip) : $signed(qclip);
            2'd1:    ny_d = neg_q[1] ? -$signed(qclip) : $signed(qclip);
            default: nz_d = qclip[14:0];
          endcase
          sel_d   = sel_q + 2'd1;
          state_d = (sel_q == 2'd2) ? N_DONE : N_DIVLOAD;
        end
      end
      N_DONE: begin
        state_d = N_IDLE;
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sel_q  <= sel_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    nz_q   <= nz_d;
  end

  assign res_o.done = (state_q == N_DONE);
  assign res_o.busy = (state_q != N_IDLE);
  assign res_o.nx   = nx_q;
  assign res_o.ny   = ny_q;
  assign res_o.nz   = nz_q;
endmodule

FILE: hw/rtl/heightmap_normal_stencil.sv
// Top level of the height map normal stencil: counters, line buffers, control.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: height; tuser: frame_start
// m_axis    out  tdata: normal_x, normal_y, normal_z, vertex_index; tuser: interior
// cfg       in   index 0 row_width, 1 row_count, 2 grid_step
//
// One vertex is in flight at a time. A row 0 vertex only fills the line
// buffers, a border vertex is sent without the normalizer, and an interior
// vertex waits for the normalizer, which scales in one-bit steps, ends the
// scaling, sums the squares, takes the root, makes the three divides and
// reports done. Each line buffer RAM is read twice per vertex, in ST_IDLE
// and ST_RD1. Reset clears the counters and control; the buffers need no
// clearing. A stalled output holds its result and the next vertex still
// enters and waits behind it.
`include "heightmap_normal_stencil_macros.svh"
module heightmap_normal_stencil
  import hns_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned HEIGHT_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // height
  input  logic [((HEIGHT_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // frame_start
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // normal_x, normal_y, normal_z, vertex_index
  output logic [71:0]                       m_axis_tdata,
  // interior
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned CW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned HB = HEIGHT_BITS;

  top_state_e state_q, state_d;
  logic [10:0] row_width_q;
  logic [12:0] row_count_q;
  logic [15:0] grid_step_q;
  logic [CW-1:0] col_q, col_d, c_q, c_d, w;
  logic [12:0]   row_q, row_d, r_q, r_d, h;
  logic [CW-1:0] c0, cn;
  logic [12:0]   r0, rn;
  logic [HB-1:0] height_q, height_d, height_in;
  logic [HB-1:0] down_q, down_d, mid_q, mid_d;
  logic          inner_q, inner_d;
  logic [21:0]   idx_q, idx_d;
  logic signed [15:0] rx_q, rx_d, ry_q, ry_d;
  logic [14:0]   rz_q, rz_d;
  logic          ov_q, ov_d;
  logic [71:0]   od_q, od_d;
  logic          ou_q, ou_d;
  logic          accept, ram_we, norm_start;
  logic [AW-1:0] old_raddr, new_raddr;
  logic [HB-1:0] old_rdata, new_rdata;
  logic signed [HB:0] dx, dy;
  logic [15:0]   step;
  norm_res_t     nres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 11'd17;
      row_count_q <= 13'd17;
      grid_step_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[10:0];
        CFG_ROW_COUNT: row_count_q <= cfg_data_i[12:0];
        CFG_GRID_STEP: grid_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(row_width_q) < MIN_DIM) w = CW'(MIN_DIM);
    else if (32'(row_width_q) > MAX_ROW_WIDTH) w = CW'(MAX_ROW_WIDTH);
    else w = CW'(row_width_q);
    if (32'(row_count_q) < MIN_DIM) h = 13'(MIN_DIM);
    else if (32'(row_count_q) > MAX_ROWS) h = 13'(MAX_ROWS);
    else h = row_count_q;
    step = (grid_step_q == '0) ? 16'd1 : grid_step_q;
  end

  // Position of the arriving vertex and of the one after it.
  always_comb begin
    c0 = s_axis_tuser ? '0 : col_q;
    r0 = s_axis_tuser ? '0 : row_q;
    if (c0 >= w) begin
      c0 = '0;
      r0 = r0 + 13'd1;
    end
    if (r0 >= h) r0 = '0;
    cn = c0 + CW'(1);
    rn = r0;
    if (cn >= w) begin
      cn = '0;
      rn = r0 + 13'd1;
      if (rn >= h) rn = '0;
    end
  end

  assign height_in     = s_axis_tdata[HB-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_we        = (state_q == ST_RD2);
  assign old_raddr     = (state_q == ST_IDLE) ? c0[AW-1:0] : c_q[AW-1:0] - AW'(1);
  assign new_raddr     = (state_q == ST_IDLE) ? c0[AW-1:0] : c_q[AW-1:0] + AW'(1);
  assign dx            = $signed({old_rdata[HB-1], old_rdata})
                       - $signed({new_rdata[HB-1], new_rdata});
  assign dy            = $signed({down_q[HB-1], down_q})
                       - $signed({height_q[HB-1], height_q});
  assign norm_start    = ram_we && inner_q;

  hns_ram #(.WIDTH(HB), .DEPTH(MAX_ROW_WIDTH)) u_older (
    .clk_i, .we_i(ram_we), .waddr_i(c_q[AW-1:0]), .wdata_i(mid_q),
    .raddr_i(old_raddr), .rdata_o(old_rdata)
  );

  hns_ram #(.WIDTH(HB), .DEPTH(MAX_ROW_WIDTH)) u_newer (
    .clk_i, .we_i(ram_we), .waddr_i(c_q[AW-1:0]), .wdata_i(height_q),
    .raddr_i(new_raddr), .rdata_o(new_rdata)
  );

  hns_norm #(.HEIGHT_BITS(HB)) u_norm (
    .clk_i, .rst_ni, .start_i(norm_start), .dx_i(dx), .dy_i(dy),
    .dz_i({step, 1'b0}), .res_o(nres)
  );

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    c_d      = c_q;
    r_d      = r_q;
    height_d = height_q;
    down_d   = down_q;
    mid_d    = mid_q;
    inner_d  = inner_q;
    idx_d    = idx_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rz_d     = rz_q;
    ov_d     = ov_q && !m_axis_tready;
    od_d     = od_q;
    ou_d     = ou_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          c_d      = c0;
          r_d      = r0;
          col_d    = cn;
          row_d    = rn;
          height_d = height_in;
          inner_d  = (r0 >= 13'd2) && (c0 != '0) && ((c0 + CW'(1)) < w);
          state_d  = ST_RD1;
        end
      end
      ST_RD1: begin
        down_d  = old_rdata;
        mid_d   = new_rdata;
        idx_d   = 22'((24'(r_q) - 24'd1) * 24'(w) + 24'(c_q));
        state_d = ST_RD2;
      end
      ST_RD2: begin
        rx_d = '0;
        ry_d = '0;
        rz_d = 15'(NORM_ONE);
        if (r_q == '0) state_d = ST_IDLE;
        else if (inner_q) state_d = ST_CALC;
        else state_d = ST_EMIT;
      end
      ST_CALC: begin
        if (nres.done) begin
          rx_d    = nres.nx;
          ry_d    = nres.ny;
          rz_d    = nres.nz;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          od_d    = {3'd0, idx_q, rz_q, ry_q, rx_q};
          ou_d    = inner_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q      <= c_d;
    r_q      <= r_d;
    height_q <= height_d;
    down_q   <= down_d;
    mid_q    <= mid_d;
    inner_q  <= inner_d;
    idx_q    <= idx_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rz_q     <= rz_d;
    od_q     <= od_d;
    ou_q     <= ou_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

  `HNS_ASSERT(a_norm_free, norm_start |-> !nres.busy, "normalizer started while busy")
  `HNS_ASSERT(a_wr_no_accept, ram_we |-> !s_axis_tready, "buffer write during accept window")
  `HNS_ASSERT(a_rise_emit, $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT), "result without emit")
  `HNS_ASSERT(a_border, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[46:0] == 47'h400000000000, "border normal wrong")
  `HNS_ASSERT_NEXT(a_done_emit, nres.done && state_q == ST_CALC, state_q == ST_EMIT, "done lost")
endmodule
